// File: rtl/step_dir_pulse_generator_macros.svh
// ----------------------------------------------------------------------------
// Step/direction pulse generator: assertion macros
// Shorthand for clocked implications used by the port checker.
// ----------------------------------------------------------------------------
`ifndef STEP_DIR_PULSE_GENERATOR_MACROS_SVH
`define STEP_DIR_PULSE_GENERATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define SDPG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SDPG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sdpg_pkg.sv
// ----------------------------------------------------------------------------
// sdpg_pkg
// Shared commands, register map and result record of the pulse generator.
// ----------------------------------------------------------------------------
package sdpg_pkg;

  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_MOVE    = 3'd1;
  localparam logic [2:0] CMD_RUN     = 3'd2;
  localparam logic [2:0] CMD_STOP    = 3'd3;
  localparam logic [2:0] CMD_SET_POS = 3'd4;

  localparam int         PADDR_BITS        = 3;
  localparam logic       REG_CLK_PER_US    = 1'b0;
  localparam logic [9:0] CLK_PER_US_RESET  = 10'd170;

  typedef struct packed {
    logic        accepted;
    logic        step_level;
    logic        direction_level;
    logic        busy_res;
    logic [31:0] position;
    logic [31:0] steps_left;
    logic        move_done;
  } sdpg_result_t;

endpackage

// File: rtl/step_dir_pulse_generator.sv
// ----------------------------------------------------------------------------
// step_dir_pulse_generator
// Single-channel stepper step/direction generator with APB prescaler register.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  in       | in_valid / in_ready  | command, step_amount, period_ticks,
//           |                      | new_position
//  out      | out_valid / out_ready| accepted, step_level, direction_level,
//           |                      | busy_res, position, steps_left, move_done
//  cfg      | APB psel/penable     | clocks_per_microsecond at offset 0
//
// One request per cycle while in_ready is high; its result is registered.
// The motion state updates in the same cycle a request is taken.
// A two-entry output buffer keeps input open into an output stall while the skid
// entry is free; in_ready drops only while both entries are full.
// Synchronous reset clears motion state and the buffer, and loads the
// prescaler register with its default of 170.
// ----------------------------------------------------------------------------
module step_dir_pulse_generator #(
  parameter int PERIOD_BITS   = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          command,
  input  logic signed [31:0]                  step_amount,
  input  logic [15:0]                         period_ticks,
  input  logic signed [31:0]                  new_position,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                accepted,
  output logic                                step_level,
  output logic                                direction_level,
  output logic                                busy_res,
  output logic signed [31:0]                  position,
  output logic [31:0]                         steps_left,
  output logic                                move_done,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sdpg_pkg::PADDR_BITS-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic                   clocks_per_us;
  logic [9:0]             clk_per_us;
  logic                   item_take;
  sdpg_pkg::sdpg_result_t core_res;
  sdpg_pkg::sdpg_result_t out_data;
  sdpg_pkg::sdpg_result_t skid_data;
  logic                   out_full;
  logic                   skid_full;

  assign pready = 1'b1;
  assign clocks_per_us = (paddr[2] == sdpg_pkg::REG_CLK_PER_US);

  always_ff @(posedge clk) begin
    if (rst) begin
      clk_per_us <= sdpg_pkg::CLK_PER_US_RESET;
    end else if (psel && penable && pwrite && pready && clocks_per_us) begin
      clk_per_us <= pwdata[9:0];
    end
  end

  assign prdata = clocks_per_us ? {22'd0, clk_per_us} : 32'd0;

  assign in_ready  = !skid_full;
  assign item_take = in_valid && in_ready;

  sdpg_core #(
    .PERIOD_BITS  (PERIOD_BITS),
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .item_take    (item_take),
    .command      (command),
    .step_amount  (step_amount),
    .period_ticks (period_ticks),
    .new_position (new_position),
    .clocks_per_us(clk_per_us),
    .result       (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_full || out_ready) begin
      // skid entry is older, drain it first
      if (skid_full) begin
        out_full  <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        out_full  <= item_take;
      end
    end else if (item_take) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_full || out_ready) begin
      out_data <= skid_full ? skid_data : core_res;
    end else if (item_take) begin
      skid_data <= core_res;
    end
  end

  assign out_valid       = out_full;
  assign accepted        = out_data.accepted;
  assign step_level      = out_data.step_level;
  assign direction_level = out_data.direction_level;
  assign busy_res        = out_data.busy_res;
  assign position        = out_data.position;
  assign steps_left      = out_data.steps_left;
  assign move_done       = out_data.move_done;

endmodule

// File: rtl/sdpg_core.sv
// ----------------------------------------------------------------------------
// sdpg_core
// Motion state and combinational next-state logic for one request.
// ----------------------------------------------------------------------------
module sdpg_core #(
  parameter int PERIOD_BITS   = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_take,
  input  logic [2:0]            command,
  input  logic signed [31:0]    step_amount,
  input  logic [15:0]           period_ticks,
  input  logic signed [31:0]    new_position,
  input  logic [9:0]            clocks_per_us,
  output sdpg_pkg::sdpg_result_t result
);

  localparam logic [31:0] PERIOD_MAX = 32'((64'(1) << PERIOD_BITS) - 64'(1));

  logic [9:0]               prescale_count,  prescale_count_next;
  logic [PERIOD_BITS-1:0]   period_count,    period_count_next;
  logic [PERIOD_BITS-1:0]   period_length,   period_length_next;
  logic [31:0]              remaining_steps, remaining_steps_next;
  logic [POSITION_BITS-1:0] step_position,   step_position_next;
  logic                     moving_forward,  moving_forward_next;
  logic                     is_running,      is_running_next;
  logic                     counted_move,    counted_move_next;

  logic                     accepted;
  logic                     done;
  logic [9:0]               div;
  logic [9:0]               pre_inc;
  logic [PERIOD_BITS-1:0]   per_inc;
  logic [31:0]              amount_u;
  logic                     amount_neg;
  logic [31:0]              amount_mag;
  logic [31:0]              rem_dec;
  logic [31:0]              period_clip;
  logic [PERIOD_BITS-1:0]   period_sat;
  logic [PERIOD_BITS-1:0]   high_len;
  logic signed [63:0]       newpos_ext;
  logic signed [63:0]       pos_ext;

  assign div        = (clocks_per_us == 10'd0) ? 10'd1 : clocks_per_us;
  assign pre_inc    = prescale_count + 10'd1;
  assign per_inc    = period_count + PERIOD_BITS'(1);
  assign amount_u   = step_amount;
  assign amount_neg = amount_u[31];
  assign amount_mag = amount_neg ? (32'd0 - amount_u) : amount_u;
  assign rem_dec    = (remaining_steps != 32'd0) ? (remaining_steps - 32'd1) : 32'd0;
  assign period_clip = (32'(period_ticks) > PERIOD_MAX) ? PERIOD_MAX : 32'(period_ticks);
  assign period_sat = PERIOD_BITS'(period_clip);
  assign newpos_ext = 64'(new_position);

  always_comb begin
    prescale_count_next  = prescale_count;
    period_count_next    = period_count;
    period_length_next   = period_length;
    remaining_steps_next = remaining_steps;
    step_position_next   = step_position;
    moving_forward_next  = moving_forward;
    is_running_next      = is_running;
    counted_move_next    = counted_move;
    accepted             = 1'b0;
    done                 = 1'b0;

    case (command)
      sdpg_pkg::CMD_TICK: begin
        accepted = 1'b1;
        if (is_running) begin
          if (pre_inc < div) begin
            prescale_count_next = pre_inc;
          end else begin
            prescale_count_next = 10'd0;
            if (per_inc < period_length) begin
              period_count_next = per_inc;
            end else begin
              // period ends: one pulse completed
              period_count_next = '0;
              if (counted_move) begin
                step_position_next = moving_forward ?
                  step_position + POSITION_BITS'(1) : step_position - POSITION_BITS'(1);
                remaining_steps_next = rem_dec;
                if (rem_dec == 32'd0) begin
                  is_running_next      = 1'b0;
                  counted_move_next    = 1'b0;
                  remaining_steps_next = 32'd0;
                  done                 = 1'b1;
                end
              end
            end
          end
        end
      end
      sdpg_pkg::CMD_MOVE: begin
        if (!is_running && period_ticks != 16'd0) begin
          accepted = 1'b1;
          // zero steps: accepted but nothing starts
          if (amount_mag != 32'd0) begin
            period_length_next   = period_sat;
            period_count_next    = '0;
            prescale_count_next  = 10'd0;
            is_running_next      = 1'b1;
            moving_forward_next  = !amount_neg;
            remaining_steps_next = amount_mag;
            counted_move_next    = 1'b1;
          end
        end
      end
      sdpg_pkg::CMD_RUN: begin
        if (!is_running && period_ticks != 16'd0) begin
          accepted             = 1'b1;
          period_length_next   = period_sat;
          period_count_next    = '0;
          prescale_count_next  = 10'd0;
          is_running_next      = 1'b1;
          counted_move_next    = 1'b0;
          remaining_steps_next = 32'd0;
        end
      end
      sdpg_pkg::CMD_STOP: begin
        accepted             = 1'b1;
        is_running_next      = 1'b0;
        counted_move_next    = 1'b0;
        remaining_steps_next = 32'd0;
        period_count_next    = '0;
        prescale_count_next  = 10'd0;
      end
      sdpg_pkg::CMD_SET_POS: begin
        if (!is_running) begin
          accepted           = 1'b1;
          step_position_next = POSITION_BITS'(newpos_ext);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count  <= 10'd0;
      period_count    <= '0;
      period_length   <= '0;
      remaining_steps <= 32'd0;
      step_position   <= '0;
      moving_forward  <= 1'b0;
      is_running      <= 1'b0;
      counted_move    <= 1'b0;
    end else if (item_take) begin
      prescale_count  <= prescale_count_next;
      period_count    <= period_count_next;
      period_length   <= period_length_next;
      remaining_steps <= remaining_steps_next;
      step_position   <= step_position_next;
      moving_forward  <= moving_forward_next;
      is_running      <= is_running_next;
      counted_move    <= counted_move_next;
    end
  end

  // high phase is half the period, at least one tick
  assign high_len = ((period_length_next >> 1) == '0) ?
                    PERIOD_BITS'(1) : (period_length_next >> 1);
  assign pos_ext  = 64'(signed'(step_position_next));

  assign result.accepted        = accepted;
  assign result.step_level      = is_running_next && (period_count_next < high_len);
  assign result.direction_level = moving_forward_next;
  assign result.busy_res        = is_running_next;
  assign result.position        = pos_ext[31:0];
  assign result.steps_left      = remaining_steps_next;
  assign result.move_done       = done;

endmodule

// File: rtl/sdpg_checker.sv
// ----------------------------------------------------------------------------
// sdpg_checker
// Port-level checks on the result stream of the pulse generator.
// ----------------------------------------------------------------------------
`include "step_dir_pulse_generator_macros.svh"

module sdpg_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        step_level,
  input logic        busy_res,
  input logic [31:0] position,
  input logic [31:0] steps_left,
  input logic        move_done
);

  // a finished move leaves the channel idle with nothing left
  `SDPG_ASSERT_IMP(a_done_idle, out_valid && move_done, !busy_res && steps_left == 32'd0, "move_done while busy or steps left")

  // no step pulse when idle
  `SDPG_ASSERT_IMP(a_idle_no_step, out_valid && !busy_res, !step_level, "step high while idle")

  // idle means no pending steps
  `SDPG_ASSERT_IMP(a_idle_no_steps, out_valid && !busy_res, steps_left == 32'd0, "steps left while idle")

  // stalled result stays valid with position and steps_left held
  `SDPG_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(position) && $stable(steps_left), "result changed under stall")

endmodule

bind step_dir_pulse_generator sdpg_checker u_sdpg_checker (.*);
